>>> hw/rtl/rtcnib_pkg.sv
package rtcnib_pkg;

	// register file
	localparam int NUM_REGS = 16;
	localparam int IDX_W    = $clog2(NUM_REGS);
	localparam int SEL_W    = 4;
	localparam int NIB_W    = 4;

	// port decode
	localparam logic [7:0] PORT_A = 8'hb8;
	localparam logic [7:0] PORT_B = 8'hb9;

	// bus access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// live time registers
	localparam logic [SEL_W-1:0] REG_SEC   = 4'd0;
	localparam logic [SEL_W-1:0] REG_MIN   = 4'd1;
	localparam logic [SEL_W-1:0] REG_HOUR  = 4'd2;
	localparam logic [SEL_W-1:0] REG_MDAY  = 4'd3;
	localparam logic [SEL_W-1:0] REG_MONTH = 4'd4;
	localparam logic [SEL_W-1:0] REG_YEAR  = 4'd5;
	localparam logic [SEL_W-1:0] REG_WDAY  = 4'd6;

	// binary to packed BCD, tens truncated to one nibble
	// v / 10 as (v * 205) >> 11, exact for v below 1029
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = {8'd0, v} * 15'd205;
		tens = prod[14:11];
		rem  = v - 7'({3'd0, tens} * 7'd10);
		return {tens, rem[3:0]};
	endfunction

endpackage

>>> hw/rtl/rtcnib_live.sv
// Live time view: picks the time field for a register number and
// converts it to BCD.
module rtcnib_live (
	input  logic [rtcnib_pkg::SEL_W-1:0] sel,
	input  logic [5:0]                   now_sec,
	input  logic [5:0]                   now_min,
	input  logic [4:0]                   now_hour,
	input  logic [4:0]                   now_mday,
	input  logic [3:0]                   now_month,
	input  logic [6:0]                   now_year,
	input  logic [2:0]                   now_wday,
	output logic                         live,
	output logic [7:0]                   live_byte
);

	logic [3:0] wday_sum;
	logic [3:0] wday_mod;
	logic [6:0] bin_val;

	// weekday as ((wday + 2) mod 7) + 1, wday + 2 stays below 14
	always_comb begin
		wday_sum = {1'b0, now_wday} + 4'd2;
		wday_mod = (wday_sum >= 4'd7) ? wday_sum - 4'd7 : wday_sum;
	end

	// field select
	always_comb begin
		live    = 1'b1;
		bin_val = '0;
		case (sel)
			rtcnib_pkg::REG_SEC:   bin_val = {1'b0, now_sec};
			rtcnib_pkg::REG_MIN:   bin_val = {1'b0, now_min};
			rtcnib_pkg::REG_HOUR:  bin_val = {2'b0, now_hour};
			rtcnib_pkg::REG_MDAY:  bin_val = {2'b0, now_mday};
			rtcnib_pkg::REG_MONTH: bin_val = {3'b0, now_month};
			rtcnib_pkg::REG_YEAR:  bin_val = now_year;
			rtcnib_pkg::REG_WDAY:  bin_val = {3'b0, wday_mod + 4'd1};
			default:               live    = 1'b0;
		endcase
	end

	assign live_byte = rtcnib_pkg::to_bcd(bin_val);

endmodule

>>> hw/rtl/rtc_nibble_register_port.sv
// Channel  Dir  Signals                     Word
// s_*      in   tvalid tready tdata tuser   one bus access plus a time snapshot
// m_*      out  tvalid tready tdata tuser   one reply per access
//
// One word per cycle sustained while m_tready is high. Stage 1 decodes
// the access and issues the register file read; its read data and decode
// feed the output register, from which the m side takes the reply word.
// Reset clears the phase, selection, pending nibble, entry valid bits and
// both valid flags; entries never written read as zero. A stalled m side
// fills the output register and stage 1 before s_tready drops.
module rtc_nibble_register_port (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] port_addr, [15:8] wr_data, [21:16] now_sec, [27:22] now_min,
	// [32:28] now_hour, [37:33] now_mday, [41:38] now_month,
	// [48:42] now_year, [51:49] now_wday, [55:52] zero
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [3:0] rd_data, [7:4] zero
	output logic        m_tuser    // [0] port_hit
);

	typedef enum logic [1:0] {
		PH_SEL  = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       hit;
		logic       rd_en;
		logic       rd_low;
		logic       live;
		logic       in_range;
		logic       ent_vld;
		logic [7:0] live_byte;
	} s1_t;

	localparam int NR = rtcnib_pkg::NUM_REGS;
	localparam int IW = rtcnib_pkg::IDX_W;
	localparam int SW = rtcnib_pkg::SEL_W;

	// input fields
	logic       op;
	logic [7:0] port_addr;
	logic [3:0] nib;

	assign op        = s_tuser;
	assign port_addr = s_tdata[7:0];
	assign nib       = s_tdata[11:8];

	phase_t         phase_q;
	logic [SW-1:0]  sel_q;
	logic [3:0]     pend_q;
	logic [NR-1:0]  vld_q;
	logic [7:0]     mem [NR];
	logic [7:0]     rdata_s1;
	s1_t            st_s1;
	logic           valid_s1;
	logic           out_vld_q;
	logic [3:0]     out_nib_q;
	logic           out_hit_q;

	logic           acc;
	logic           adv;
	logic           hit;
	logic           live;
	logic [7:0]     live_byte;
	logic           in_range;
	logic [IW-1:0]  idx;
	logic           wr_en;
	logic           rd_en;
	logic [7:0]     byte_s1;
	logic [3:0]     nib_s1;

	rtcnib_live u_live (
		.sel       (sel_q),
		.now_sec   (s_tdata[21:16]),
		.now_min   (s_tdata[27:22]),
		.now_hour  (s_tdata[32:28]),
		.now_mday  (s_tdata[37:33]),
		.now_month (s_tdata[41:38]),
		.now_year  (s_tdata[48:42]),
		.now_wday  (s_tdata[51:49]),
		.live      (live),
		.live_byte (live_byte)
	);

	// handshake: stage 1 moves on when the output register is empty or being taken
	assign adv      = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign acc      = s_tvalid && s_tready;

	// decode
	assign hit      = (port_addr == rtcnib_pkg::PORT_A) || (port_addr == rtcnib_pkg::PORT_B);
	assign in_range = {1'b0, sel_q} < (SW+1)'(NR);
	assign idx      = sel_q[IW-1:0];
	assign wr_en    = acc && hit && (op == rtcnib_pkg::OP_WRITE) && (phase_q == PH_LOW)
		&& in_range;
	assign rd_en    = hit && (op == rtcnib_pkg::OP_READ)
		&& ((phase_q == PH_HIGH) || (phase_q == PH_LOW));

	// phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEL;
			sel_q   <= '0;
			pend_q  <= '0;
		end else if (acc && hit) begin
			case (phase_q)
				PH_SEL: begin
					if (op == rtcnib_pkg::OP_WRITE) begin
						sel_q   <= nib;
						phase_q <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (op == rtcnib_pkg::OP_WRITE) begin
						pend_q <= nib;
					end
					phase_q <= PH_LOW;
				end
				PH_LOW:  phase_q <= PH_SEL;
				default: phase_q <= PH_SEL;
			endcase
		end
	end

	// register file, entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[idx] <= 1'b1;
		end
	end

	// register file: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= {pend_q, nib};
		end
		if (acc && rd_en && in_range) begin
			rdata_s1 <= mem[idx];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			st_s1.hit       <= hit;
			st_s1.rd_en     <= rd_en;
			st_s1.rd_low    <= (phase_q == PH_LOW);
			st_s1.live      <= live;
			st_s1.in_range  <= in_range;
			st_s1.ent_vld   <= in_range && vld_q[idx];
			st_s1.live_byte <= live_byte;
		end
	end

	// reply nibble
	always_comb begin
		if (st_s1.live) begin
			byte_s1 = st_s1.live_byte;
		end else if (st_s1.in_range && st_s1.ent_vld) begin
			byte_s1 = rdata_s1;
		end else begin
			byte_s1 = '0;
		end
		if (!st_s1.rd_en) begin
			nib_s1 = '0;
		end else if (st_s1.rd_low) begin
			nib_s1 = byte_s1[3:0];
		end else begin
			nib_s1 = byte_s1[7:4];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_nib_q <= nib_s1;
			out_hit_q <= st_s1.hit;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_nib_q};
	assign m_tuser  = out_hit_q;

endmodule

>>> dv/rtc_nibble_register_port_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each reply from the accepted access and
// compares it against the reply word that comes out.
module rtc_nibble_register_port_checker
	import rtcnib_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [7:0] port_addr, [15:8] wr_data, [21:16] now_sec, [27:22] now_min,
	// [32:28] now_hour, [37:33] now_mday, [41:38] now_month,
	// [48:42] now_year, [51:49] now_wday, [55:52] zero
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,   // [0] op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [3:0] rd_data, [7:4] zero
	input  logic        m_tuser,   // [0] port_hit
	output int          fail_count,
	output int          outstanding,
	output int          reply_count,
	output int          hit_count
);

	typedef enum logic [1:0] {PH_SELECT, PH_HIGH, PH_LOW, PH_STUCK} access_phase_t;

	typedef struct packed {
		logic [NIB_W-1:0] nibble;
		logic             hit;
	} reply_t;

	// shadow of the port state
	access_phase_t    phase;
	logic [SEL_W-1:0] sel_index;
	logic [NIB_W-1:0] pending_high;
	logic [7:0]       stored_regs [NUM_REGS];
	reply_t           expected_replies [$];

	function automatic logic [7:0] bin_to_bcd(input int unsigned v);
		return 8'(((v / 10) << 4) | (v % 10));
	endfunction

	// byte a read sees: live time for the low registers, stored byte otherwise
	function automatic logic [7:0] register_byte(input logic [SEL_W-1:0] idx,
			input logic [55:0] word);
		case (idx)
			REG_SEC:   return bin_to_bcd(word[21:16]);
			REG_MIN:   return bin_to_bcd(word[27:22]);
			REG_HOUR:  return bin_to_bcd(word[32:28]);
			REG_MDAY:  return bin_to_bcd(word[37:33]);
			REG_MONTH: return bin_to_bcd(word[41:38]);
			REG_YEAR:  return bin_to_bcd(word[48:42]);
			REG_WDAY:  return bin_to_bcd(((int'(word[51:49]) + 2) % 7) + 1);
			default:   return (int'(idx) < NUM_REGS) ? stored_regs[idx] : 8'h00;
		endcase
	endfunction

	// advances the shadow state by one access and returns its reply
	function automatic reply_t predict_access(input logic op, input logic [55:0] word);
		logic [7:0]       addr;
		logic [NIB_W-1:0] nib;
		logic [7:0]       reg_byte;
		reply_t           r;
		addr     = word[7:0];
		nib      = word[11:8];
		r.nibble = '0;
		r.hit    = (addr == PORT_A) || (addr == PORT_B);
		reg_byte = register_byte(sel_index, word);
		if (r.hit) begin
			if (op == OP_WRITE) begin
				case (phase)
					PH_SELECT: begin
						sel_index = nib;
						phase     = PH_HIGH;
					end
					PH_HIGH: begin
						pending_high = nib;
						phase        = PH_LOW;
					end
					PH_LOW: begin
						if (int'(sel_index) < NUM_REGS)
							stored_regs[sel_index] = {pending_high, nib};
						phase = PH_SELECT;
					end
					default: phase = PH_SELECT;
				endcase
			end else begin
				case (phase)
					PH_HIGH: begin
						r.nibble = reg_byte[7:4];
						phase    = PH_LOW;
					end
					PH_LOW: begin
						r.nibble = reg_byte[3:0];
						phase    = PH_SELECT;
					end
					PH_SELECT: ;
					default: phase = PH_SELECT;
				endcase
			end
		end
		return r;
	endfunction

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t next_reply;
		reply_t want;
		if (!arst_n) begin
			phase        = PH_SELECT;
			sel_index    = '0;
			pending_high = '0;
			foreach (stored_regs[i])
				stored_regs[i] = 8'h00;
			expected_replies.delete();
			fail_count  = 0;
			reply_count = 0;
			hit_count   = 0;
		end else begin
			// accepted access: predict and queue its reply
			if (s_tvalid && s_tready) begin
				next_reply = predict_access(s_tuser, s_tdata);
				expected_replies.push_back(next_reply);
				if (next_reply.hit)
					hit_count++;
			end
			// accepted reply word: compare against the oldest prediction
			if (m_tvalid && m_tready) begin
				reply_count++;
				if (expected_replies.size() == 0) begin
					report("unexpected reply word", 0, m_tdata);
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[3:0] !== want.nibble)
						report("rd_data", want.nibble, m_tdata[3:0]);
					if (m_tdata[7:4] !== 4'h0)
						report("tdata pad", 0, m_tdata[7:4]);
					if (m_tuser !== want.hit)
						report("port_hit", want.hit, m_tuser);
				end
			end
		end
		outstanding = expected_replies.size();
	end

endmodule

>>> dv/rtc_nibble_register_port_tb.sv
`timescale 1ns / 100ps

module rtc_nibble_register_port_tb;
	import rtcnib_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int RANDOM_HITS = 800;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] mday;
		logic [3:0] month;
		logic [6:0] year;
		logic [2:0] wday;
	} time_snap_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	int fail_count;
	int outstanding;
	int reply_count;
	int hit_count;
	int cycle_count;
	int random_hits;
	bit long_hold_req;

	rtc_nibble_register_port u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rtc_nibble_register_port_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.reply_count (reply_count),
		.hit_count   (hit_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("rtc_nibble_register_port_tb failed");
			$finish;
		end
	end

	function automatic logic [55:0] access_word(input logic [7:0] addr,
			input logic [7:0] data, input time_snap_t t);
		return {4'd0, t.wday, t.year, t.month, t.mday, t.hour, t.min, t.sec, data, addr};
	endfunction

	// mostly a plausible time, sometimes any bit pattern
	function automatic time_snap_t random_snap();
		time_snap_t t;
		if ($urandom_range(0, 3) != 0) begin
			t.sec   = 6'($urandom_range(0, 59));
			t.min   = 6'($urandom_range(0, 59));
			t.hour  = 5'($urandom_range(0, 23));
			t.mday  = 5'($urandom_range(1, 31));
			t.month = 4'($urandom_range(0, 11));
			t.year  = 7'($urandom_range(0, 99));
			t.wday  = 3'($urandom_range(0, 6));
		end else begin
			t = time_snap_t'({$urandom, $urandom});
		end
		return t;
	endfunction

	function automatic logic [7:0] hit_addr();
		return $urandom_range(0, 1) ? PORT_B : PORT_A;
	endfunction

	function automatic logic [7:0] miss_addr();
		logic [7:0] a;
		do
			a = 8'($urandom);
		while (a == PORT_A || a == PORT_B);
		return a;
	endfunction

	function automatic int random_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// offer one word, hold it until taken, then idle for the gap if one is given
	task automatic issue_access(input logic op, input logic [7:0] addr,
			input logic [7:0] data, input time_snap_t t, input int gap);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= access_word(addr, data, t);
		do
			@(posedge clk);
		while (!s_tready);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending until every predicted reply has come back
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// reply side: random ready bursts and stalls, plus one long hold-off on request
	initial begin
		int r;
		bit hold_taken;
		m_tready <= 1'b0;
		hold_taken = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (r < 60) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else if (r < 68) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else if (r < 92) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(8, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		time_snap_t zero_t;
		time_snap_t max_t;
		bit         quiet;
		bit         hold_done;
		bit         pause_done;
		int         idx;
		logic [7:0] addr;
		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tuser       <= OP_READ;
		s_tdata       <= '0;
		long_hold_req = 1'b0;
		random_hits   = 0;
		hold_done     = 1'b0;
		pause_done    = 1'b0;
		zero_t        = '0;
		max_t         = '1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// misses around the port addresses, and a read before any selection
		issue_access(OP_READ,  8'h00, 8'h00, zero_t, 0);
		issue_access(OP_WRITE, 8'hff, 8'hff, max_t, 0);
		issue_access(OP_WRITE, 8'hb7, 8'h03, zero_t, 0);
		issue_access(OP_READ,  8'hba, 8'h00, max_t, 1);
		issue_access(OP_READ,  PORT_A, 8'h00, max_t, 0);
		// store 0x5c in the top register, upper data bits set, then read it back
		issue_access(OP_WRITE, PORT_B, 8'hff, zero_t, 0);
		issue_access(OP_WRITE, PORT_A, 8'ha5, zero_t, 0);
		issue_access(OP_WRITE, PORT_B, 8'h0c, zero_t, 0);
		issue_access(OP_WRITE, PORT_A, 8'h0f, zero_t, 0);
		issue_access(OP_READ,  PORT_B, 8'h00, max_t, 0);
		issue_access(OP_READ,  PORT_A, 8'h00, zero_t, 2);
		// live seconds with every time bit set
		issue_access(OP_WRITE, PORT_A, 8'hf0, zero_t, 0);
		issue_access(OP_READ,  PORT_A, 8'h00, max_t, 0);
		issue_access(OP_READ,  PORT_B, 8'h00, max_t, 0);
		// write to the live year register, then read the live value back
		issue_access(OP_WRITE, PORT_B, 8'h05, zero_t, 0);
		issue_access(OP_WRITE, PORT_B, 8'hff, zero_t, 0);
		issue_access(OP_WRITE, PORT_A, 8'hff, zero_t, 0);
		issue_access(OP_WRITE, PORT_A, 8'h05, zero_t, 0);
		issue_access(OP_READ,  PORT_B, 8'h00, max_t, 0);
		issue_access(OP_READ,  PORT_B, 8'h00, max_t, 0);
		// high nibble read, then low nibble write: stores with the old high nibble
		issue_access(OP_WRITE, PORT_A, 8'h07, zero_t, 0);
		issue_access(OP_READ,  PORT_A, 8'h00, zero_t, 0);
		issue_access(OP_WRITE, PORT_B, 8'h09, zero_t, 0);
		drain_replies();

		// random part: mostly select/nibble/nibble sequences, some noise
		while (random_hits < RANDOM_HITS) begin
			quiet = ($urandom_range(0, 4) == 0);
			if (random_hits >= 300 && !hold_done) begin
				long_hold_req = 1'b1;
				hold_done     = 1'b1;
			end
			if (random_hits >= 500 && !pause_done) begin
				drain_replies();
				pause_done = 1'b1;
			end
			if ($urandom_range(0, 99) < 75) begin
				idx = ($urandom_range(0, 9) < 6) ? $urandom_range(7, 15) : $urandom_range(0, 6);
				issue_access(OP_WRITE, hit_addr(), {4'($urandom), 4'(idx)}, random_snap(),
					random_gap(quiet));
				random_hits++;
				repeat (2) begin
					if ($urandom_range(0, 99) < 15)
						issue_access(1'($urandom), miss_addr(), 8'($urandom), random_snap(),
							random_gap(quiet));
					issue_access(1'($urandom), hit_addr(), 8'($urandom), random_snap(),
						random_gap(quiet));
					random_hits++;
				end
			end else begin
				addr = $urandom_range(0, 1) ? hit_addr() : 8'($urandom);
				issue_access(1'($urandom), addr, 8'($urandom), random_snap(), random_gap(quiet));
				if (addr == PORT_A || addr == PORT_B)
					random_hits++;
			end
		end

		drain_replies();
		repeat (8) @(posedge clk);

		$display("Checked %0d reply words, %0d of them port hits", reply_count, hit_count);
		$display("Covered misses, phase order, live BCD, stored registers, %0d random hits",
			random_hits);
		if (fail_count == 0 && outstanding == 0)
			$display("rtc_nibble_register_port_tb passed");
		else
			$display("rtc_nibble_register_port_tb failed");
		$finish;
	end

endmodule
